[src/ltre_pkg.sv]
package ltre_pkg;

  // default store geometry
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // field widths
  localparam int CW    = 12;
  localparam int ZW    = 17;
  localparam int COLW  = 32;
  localparam int CNTW  = 15;
  localparam int IN_DW  = 160;
  localparam int OUT_DW = 64;

  // depth fixed point
  localparam int DEPTH_FRAC_BITS = 16;
  localparam logic [ZW-1:0] DEPTH_ONE = ZW'(1) << DEPTH_FRAC_BITS;
  localparam logic [CNTW-1:0] COUNT_CAP = CNTW'(16384);

  // operations
  localparam logic [1:0] OP_LINE = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEPTH     = 2'd1;
  localparam logic [1:0] ST_AREA      = 2'd2;
  localparam logic [1:0] ST_OFFSCREEN = 2'd3;

endpackage

[src/line_triangle_raster_engine.sv]
// Raster engine: draws lines and depth-tested triangles into a colour store
// and a depth store of MAX_WIDTH x MAX_HEIGHT pixels, and reads pixels back.
// Requests arrive on the in_ stream (tuser = op, tdata = vertices, depths,
// paint); each request yields exactly one result on the out_ stream
// (tuser = status, tdata = read colour, read depth, pixels written).
// frame_width / frame_height live on the APB port at 0x0 and 0x4.
// One request is worked at a time. What each request does:
//   read: one registered store read, skipped when off screen; unused op: none;
//   line: walks the major axis pixel by pixel, painting the on-screen ones;
//   triangle: ends early when a depth is out of range, when the area is not
//   negative or when the box is empty; else it visits each pixel of the clamped
//   bounding box, and each covered pixel takes 4 multiply-accumulate steps, a 17-step
//   restoring divider and the depth-store read-modify-write.
// The stores are single-write, single-read synchronous RAMs; the per-pixel
// divider sets the triangle rate.
// After reset a clearing pass zeroes every pixel of both stores;
// in_tready stays low meanwhile, config writes are taken as ever.
// Results sit in an output register; while the receiver stalls, a new
// request is still taken once the current one has reached that register.
module line_triangle_raster_engine #(
  parameter int MAX_WIDTH  = ltre_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ltre_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // ax[11:0] ay[23:12] bx[35:24] by[47:36] cx[59:48] cy[71:60]
  // az[88:72] bz[105:89] cz[122:106] paint[154:123], zero above
  input  logic [ltre_pkg::IN_DW-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // read_colour[31:0] read_depth[48:32] pixels_written[63:49]
  output logic [ltre_pkg::OUT_DW-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                  out_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ltre_pkg::*;

  localparam int PIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_L0    = 5'd2;
  localparam logic [4:0] S_L1    = 5'd3;
  localparam logic [4:0] S_LSTEP = 5'd4;
  localparam logic [4:0] S_T0    = 5'd5;
  localparam logic [4:0] S_TSET  = 5'd6;
  localparam logic [4:0] S_TCHK  = 5'd7;
  localparam logic [4:0] S_TPIX  = 5'd8;
  localparam logic [4:0] S_TMUL  = 5'd9;
  localparam logic [4:0] S_TDIV  = 5'd10;
  localparam logic [4:0] S_TWR   = 5'd11;
  localparam logic [4:0] S_R0    = 5'd12;
  localparam logic [4:0] S_R1    = 5'd13;
  localparam logic [4:0] S_R2    = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  logic [4:0] state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic [7:0] fw_r, fh_r;

  // request registers
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [ZW-1:0] az_r, bz_r, cz_r;
  logic [COLW-1:0] paint_r;

  // result being built
  logic [1:0]      res_status_r;
  logic [COLW-1:0] res_colour_r;
  logic [ZW-1:0]   res_depth_r;
  logic [CNTW-1:0] cnt_r;

  // output register
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [COLW-1:0] out_colour_r;
  logic [ZW-1:0]   out_depth_r;
  logic [CNTW-1:0] out_cnt_r;

  // line walker
  logic                 lsw_r, lup_r;
  logic signed [12:0]   lx_r, ly_r;
  logic signed [CW-1:0] lu0_r, lv0_r, lu1_r, lv1_r, lxe_r;
  logic [12:0]          ldx_r;
  logic [13:0]          lde_r;
  logic signed [15:0]   err_r;

  // triangle setup and scan
  logic signed [CW-1:0] lox_r, loy_r, hix_r, hiy_r, tx_r, ty_r;
  logic signed [12:0]   xs_r [3];
  logic signed [12:0]   ys_r [3];
  logic signed [27:0]   wc_r [3];
  logic signed [27:0]   wr_r [3];
  logic signed [27:0]   s_r;
  logic signed [25:0]   prod_r, hold_r;
  logic [3:0]           k_r;
  logic [26:0]          dv_r;
  logic [26:0]          nw_r [3];
  logic [1:0]           m_r;
  logic [43:0]          mprod_r, num_r;
  logic [26:0]          rem_r;
  logic [16:0]          low_r;
  logic [ZW-1:0]        q_r;
  logic [4:0]           dcnt_r;
  logic [AW-1:0]        addr_r;

  // memories
  logic            col_we, dep_we;
  logic [AW-1:0]   col_waddr;
  logic [COLW-1:0] col_wdata, col_rdata;
  logic [ZW-1:0]   dep_wdata, dep_rdata;

  // active screen, saturated to the store size
  logic [12:0] scr_w, scr_h;
  assign scr_w = ({5'd0, fw_r} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {5'd0, fw_r};
  assign scr_h = ({5'd0, fh_r} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {5'd0, fh_r};

  function automatic logic on_screen(logic signed [12:0] px, logic signed [12:0] py,
                                     logic [12:0] sw, logic [12:0] sh);
    return !px[12] && !py[12] && ($unsigned(px) < sw) && ($unsigned(py) < sh);
  endfunction

  function automatic logic [AW-1:0] pix_addr(logic [CW-1:0] px, logic [CW-1:0] py);
    return AW'(32'(py) * 32'(MAX_WIDTH) + 32'(px));
  endfunction

  function automatic logic signed [CW-1:0] min3(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b,
                                               logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CW-1:0] max3(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b,
                                               logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [12:0] sx(logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = {24'd0, paddr[2] ? fh_r : fw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 8'd128;
      fh_r <= 8'd128;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        fh_r <= pwdata[7:0];
      end else begin
        fw_r <= pwdata[7:0];
      end
    end
  end

  // line: current pixel
  logic signed [12:0] lpx, lpy;
  logic               l_in;
  logic signed [15:0] err_add, err_n;
  logic               l_stepy;
  assign lpx     = lsw_r ? ly_r : lx_r;
  assign lpy     = lsw_r ? lx_r : ly_r;
  assign l_in    = on_screen(lpx, lpy, scr_w, scr_h);
  assign err_add = err_r + $signed({2'b0, lde_r});
  assign l_stepy = err_add >= $signed({3'b0, ldx_r});
  assign err_n   = l_stepy ? err_add - $signed({2'b0, ldx_r, 1'b0}) : err_add;

  // line setup: major-axis choice
  logic signed [12:0] dxa, dya;
  logic [12:0]        adx, ady;
  logic               l_sw;
  assign dxa  = sx(bx_r) - sx(ax_r);
  assign dya  = sx(by_r) - sx(ay_r);
  assign adx  = dxa[12] ? 13'(-dxa) : dxa;
  assign ady  = dya[12] ? 13'(-dya) : dya;
  assign l_sw = adx < ady;

  // line setup: endpoint order
  logic                 l_flip;
  logic signed [CW-1:0] lxs, lys, lye;
  logic signed [12:0]   ldv;
  assign l_flip = lu0_r > lu1_r;
  assign lxs    = l_flip ? lu1_r : lu0_r;
  assign lys    = l_flip ? lv1_r : lv0_r;
  assign lye    = l_flip ? lv0_r : lv1_r;
  assign ldv    = sx(lye) - sx(lys);

  // triangle: depth range and clamped box
  logic                 z_bad;
  logic signed [CW-1:0] mnx, mny, mxx, mxy;
  logic signed [13:0]   wlim, hlim;
  assign z_bad = (az_r == '0) || (az_r > DEPTH_ONE) || (bz_r == '0) ||
                 (bz_r > DEPTH_ONE) || (cz_r == '0) || (cz_r > DEPTH_ONE);
  assign mnx  = min3(ax_r, bx_r, cx_r);
  assign mny  = min3(ay_r, by_r, cy_r);
  assign mxx  = max3(ax_r, bx_r, cx_r);
  assign mxy  = max3(ay_r, by_r, cy_r);
  assign wlim = $signed({1'b0, scr_w}) - 14'sd1;
  assign hlim = $signed({1'b0, scr_h}) - 14'sd1;

  // triangle setup: one 13x13 product per step
  logic signed [CW-1:0] oa1, oa2, ob1, ob2;
  logic signed [12:0]   ma, mb;
  logic signed [27:0]   tdiff;
  always_comb begin
    unique case (k_r[2:0])
      3'd0: begin oa1 = cx_r;  oa2 = ax_r; ob1 = by_r;  ob2 = ay_r; end
      3'd1: begin oa1 = bx_r;  oa2 = ax_r; ob1 = cy_r;  ob2 = ay_r; end
      3'd2: begin oa1 = lox_r; oa2 = bx_r; ob1 = cy_r;  ob2 = by_r; end
      3'd3: begin oa1 = cx_r;  oa2 = bx_r; ob1 = loy_r; ob2 = by_r; end
      3'd4: begin oa1 = lox_r; oa2 = cx_r; ob1 = ay_r;  ob2 = cy_r; end
      3'd5: begin oa1 = ax_r;  oa2 = cx_r; ob1 = loy_r; ob2 = cy_r; end
      3'd6: begin oa1 = lox_r; oa2 = ax_r; ob1 = by_r;  ob2 = ay_r; end
      default: begin oa1 = bx_r; oa2 = ax_r; ob1 = loy_r; ob2 = ay_r; end
    endcase
  end
  assign ma    = sx(oa1) - sx(oa2);
  assign mb    = sx(ob1) - sx(ob2);
  assign tdiff = 28'(hold_r) - 28'(prod_r);

  // per-pixel coverage
  logic t_cov;
  assign t_cov = (wc_r[0][27] || wc_r[0] == '0) && (wc_r[1][27] || wc_r[1] == '0) &&
                 (wc_r[2][27] || wc_r[2] == '0);

  // depth numerator multiply
  logic [ZW-1:0] zsel;
  logic [26:0]   nwsel;
  logic [43:0]   num_sum;
  always_comb begin
    unique case (m_r)
      2'd0:    begin zsel = az_r; nwsel = nw_r[0]; end
      2'd1:    begin zsel = bz_r; nwsel = nw_r[1]; end
      default: begin zsel = cz_r; nwsel = nw_r[2]; end
    endcase
  end
  assign num_sum = num_r + mprod_r;

  // restoring divider step
  logic [27:0] dtry;
  logic        dfit;
  assign dtry = {rem_r, low_r[16]};
  assign dfit = dtry >= {1'b0, dv_r};

  // depth test
  logic t_pass;
  assign t_pass = !(q_r < dep_rdata);

  // scan advance
  logic t_adv, t_last_x, t_last;
  assign t_adv    = ((state_r == S_TPIX) && !t_cov) || (state_r == S_TWR);
  assign t_last_x = tx_r == hix_r;
  assign t_last   = t_last_x && (ty_r == hiy_r);

  // store write ports
  always_comb begin
    col_we    = 1'b0;
    dep_we    = 1'b0;
    col_waddr = addr_r;
    col_wdata = paint_r;
    dep_wdata = q_r;
    if (state_r == S_CLR) begin
      col_we    = 1'b1;
      dep_we    = 1'b1;
      col_waddr = clr_r;
      col_wdata = '0;
      dep_wdata = '0;
    end else if (state_r == S_LSTEP) begin
      col_we    = l_in;
      col_waddr = pix_addr(lpx[CW-1:0], lpy[CW-1:0]);
    end else if (state_r == S_TWR) begin
      col_we = t_pass;
      dep_we = t_pass;
    end
  end

  ltre_ram #(.WIDTH(COLW), .DEPTH(PIX)) u_colour (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (addr_r),
    .rdata (col_rdata)
  );

  ltre_ram #(.WIDTH(ZW), .DEPTH(PIX)) u_depth (
    .clk   (clk),
    .we    (dep_we),
    .waddr (col_waddr),
    .wdata (dep_wdata),
    .raddr (addr_r),
    .rdata (dep_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_r == AW'(PIX - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            OP_LINE: state_nxt = S_L0;
            OP_TRI:  state_nxt = S_T0;
            OP_READ: state_nxt = S_R0;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_L0:    state_nxt = S_L1;
      S_L1:    state_nxt = S_LSTEP;
      S_LSTEP: if (lx_r == sx(lxe_r)) state_nxt = S_DONE;
      S_T0:    state_nxt = z_bad ? S_DONE : S_TSET;
      S_TSET:  if (k_r == 4'd8) state_nxt = S_TCHK;
      S_TCHK: begin
        if (s_r >= 0 || lox_r > hix_r || loy_r > hiy_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TPIX;
        end
      end
      S_TPIX:  state_nxt = t_cov ? S_TMUL : (t_last ? S_DONE : S_TPIX);
      S_TMUL:  if (m_r == 2'd3) state_nxt = S_TDIV;
      S_TDIV:  if (dcnt_r == 5'd16) state_nxt = S_TWR;
      S_TWR:   state_nxt = t_last ? S_DONE : S_TPIX;
      S_R0:    state_nxt = on_screen(sx(ax_r), sx(ay_r), scr_w, scr_h) ? S_R1 : S_DONE;
      S_R1:    state_nxt = S_R2;
      S_R2:    state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  assign in_tready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ax_r    <= in_tdata[11:0];
        ay_r    <= in_tdata[23:12];
        bx_r    <= in_tdata[35:24];
        by_r    <= in_tdata[47:36];
        cx_r    <= in_tdata[59:48];
        cy_r    <= in_tdata[71:60];
        az_r    <= in_tdata[88:72];
        bz_r    <= in_tdata[105:89];
        cz_r    <= in_tdata[122:106];
        paint_r <= in_tdata[154:123];
        res_status_r <= ST_OK;
        res_colour_r <= '0;
        res_depth_r  <= '0;
        cnt_r        <= '0;
      end
      S_L0: begin
        lsw_r <= l_sw;
        lu0_r <= l_sw ? ay_r : ax_r;
        lv0_r <= l_sw ? ax_r : ay_r;
        lu1_r <= l_sw ? by_r : bx_r;
        lv1_r <= l_sw ? bx_r : by_r;
      end
      S_L1: begin
        lx_r  <= sx(lxs);
        lxe_r <= l_flip ? lu0_r : lu1_r;
        ly_r  <= sx(lys);
        ldx_r <= 13'(sx(l_flip ? lu0_r : lu1_r) - sx(lxs));
        lde_r <= ldv[12] ? {13'(-ldv), 1'b0} : {ldv, 1'b0};
        lup_r <= lye > lys;
        err_r <= '0;
      end
      S_LSTEP: begin
        if (l_in && cnt_r < COUNT_CAP) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
        err_r <= err_n;
        if (l_stepy) begin
          ly_r <= lup_r ? ly_r + 13'sd1 : ly_r - 13'sd1;
        end
        lx_r <= lx_r + 13'sd1;
      end
      S_T0: begin
        if (z_bad) begin
          res_status_r <= ST_DEPTH;
        end
        lox_r <= mnx[CW-1] ? '0 : mnx;
        loy_r <= mny[CW-1] ? '0 : mny;
        hix_r <= ($signed({{2{mxx[CW-1]}}, mxx}) > wlim) ? wlim[CW-1:0] : mxx;
        hiy_r <= ($signed({{2{mxy[CW-1]}}, mxy}) > hlim) ? hlim[CW-1:0] : mxy;
        xs_r[0] <= sx(cy_r) - sx(by_r);
        xs_r[1] <= sx(ay_r) - sx(cy_r);
        xs_r[2] <= sx(by_r) - sx(ay_r);
        ys_r[0] <= sx(bx_r) - sx(cx_r);
        ys_r[1] <= sx(cx_r) - sx(ax_r);
        ys_r[2] <= sx(ax_r) - sx(bx_r);
        k_r     <= '0;
      end
      S_TSET: begin
        prod_r <= ma * mb;
        k_r    <= k_r + 4'd1;
        if (k_r != 4'd0) begin
          if (!k_r[0]) begin
            // odd product step closes one difference
            unique case (k_r[2:1])
              2'd1:    s_r     <= tdiff;
              2'd2:    wc_r[0] <= tdiff;
              2'd3:    wc_r[1] <= tdiff;
              default: wc_r[2] <= tdiff;
            endcase
          end else begin
            hold_r <= prod_r;
          end
        end
      end
      S_TCHK: begin
        if (s_r == '0) begin
          res_status_r <= ST_AREA;
        end
        dv_r    <= 27'(-s_r);
        tx_r    <= lox_r;
        ty_r    <= loy_r;
        wr_r[0] <= wc_r[0];
        wr_r[1] <= wc_r[1];
        wr_r[2] <= wc_r[2];
      end
      S_TPIX: begin
        if (t_cov) begin
          addr_r  <= pix_addr(tx_r, ty_r);
          nw_r[0] <= 27'(-wc_r[0]);
          nw_r[1] <= 27'(-wc_r[1]);
          nw_r[2] <= 27'(-wc_r[2]);
          m_r     <= '0;
          num_r   <= '0;
          mprod_r <= '0;
        end
      end
      S_TMUL: begin
        mprod_r <= nwsel * zsel;
        num_r   <= num_sum;
        m_r     <= m_r + 2'd1;
        if (m_r == 2'd3) begin
          rem_r  <= num_sum[43:17];
          low_r  <= num_sum[16:0];
          q_r    <= '0;
          dcnt_r <= '0;
        end
      end
      S_TDIV: begin
        rem_r  <= dfit ? 27'(dtry - {1'b0, dv_r}) : dtry[26:0];
        q_r    <= {q_r[ZW-2:0], dfit};
        low_r  <= {low_r[15:0], 1'b0};
        dcnt_r <= dcnt_r + 5'd1;
      end
      S_TWR: begin
        if (t_pass && cnt_r < COUNT_CAP) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
      end
      S_R0: begin
        if (on_screen(sx(ax_r), sx(ay_r), scr_w, scr_h)) begin
          addr_r <= pix_addr(ax_r, ay_r);
        end else begin
          res_status_r <= ST_OFFSCREEN;
        end
      end
      S_R2: begin
        res_colour_r <= col_rdata;
        res_depth_r  <= dep_rdata;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_status_r <= res_status_r;
          out_colour_r <= res_colour_r;
          out_depth_r  <= res_depth_r;
          out_cnt_r    <= cnt_r;
        end
      end
      default: begin
      end
    endcase

    // step across the box: along x, or to the next row
    if (t_adv && !t_last) begin
      if (t_last_x) begin
        tx_r <= lox_r;
        ty_r <= ty_r + CW'(1);
        for (int i = 0; i < 3; i++) begin
          wr_r[i] <= wr_r[i] + 28'(ys_r[i]);
          wc_r[i] <= wr_r[i] + 28'(ys_r[i]);
        end
      end else begin
        tx_r <= tx_r + CW'(1);
        for (int i = 0; i < 3; i++) begin
          wc_r[i] <= wc_r[i] + 28'(xs_r[i]);
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_cnt_r, out_depth_r, out_colour_r};

endmodule

[src/ltre_ram.sv]
module ltre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/ltre_checker.sv]
module ltre_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ltre_pkg::OUT_DW-1:0] out_tdata,
  input logic [1:0]                  out_tuser
);
  import ltre_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // failed or off-screen requests draw nothing
  a_fail_nodraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[63:49] == '0)
    else $error("pixels counted on failed request");

  // off-screen read returns zero data
  a_bad_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OFFSCREEN |-> out_tdata[48:0] == '0)
    else $error("data on off-screen read");

endmodule

bind line_triangle_raster_engine ltre_checker u_ltre_checker (.*);

[test/raster_checker.sv]
`timescale 1ns / 100ps

// Watches the request, result and register ports of the raster engine,
// keeps its own copy of both pixel stores and the screen size, and checks
// every result against the oldest predicted one.
module raster_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [ltre_pkg::IN_DW-1:0]  in_tdata,
  input  logic [1:0]                  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [ltre_pkg::OUT_DW-1:0] out_tdata,
  input  logic [1:0]                  out_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);
  import ltre_pkg::*;

  localparam int SIDE = 128;

  typedef struct packed {
    logic [1:0]      status;
    logic [COLW-1:0] colour;
    logic [ZW-1:0]   depth;
    logic [CNTW-1:0] count;
  } pixel_result_t;

  pixel_result_t   result_q[$];
  logic [COLW-1:0] colour_mem[SIDE*SIDE];
  logic [ZW-1:0]   depth_mem[SIDE*SIDE];
  logic [7:0]      frame_w;
  logic [7:0]      frame_h;

  initial begin
    fail_count = 0;
    frame_w = 8'd128;
    frame_h = 8'd128;
    for (int i = 0; i < SIDE*SIDE; i++) begin
      colour_mem[i] = '0;
      depth_mem[i] = '0;
    end
  end

  assign pending = result_q.size();

  function automatic int clip_dim(input logic [7:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic longint edge_fn(input longint x0, y0, x1, y1, px, py);
    return (px - x0) * (y1 - y0) - (x1 - x0) * (py - y0);
  endfunction

  function automatic int abs_i(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Bresenham walk along the major axis, colour only
  function automatic logic [CNTW-1:0] draw_line(input int x0, y0, x1, y1,
                                                input logic [COLW-1:0] col);
    int w, h, t, dx, de, stp, err, y, px, py, cnt;
    bit steep;
    w = clip_dim(frame_w);
    h = clip_dim(frame_h);
    cnt = 0;
    steep = abs_i(x1 - x0) < abs_i(y1 - y0);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    de = 2 * abs_i(y1 - y0);
    stp = (y1 > y0) ? 1 : -1;
    err = 0;
    y = y0;
    for (int x = x0; x <= x1; x++) begin
      px = steep ? y : x;
      py = steep ? x : y;
      if (px >= 0 && px < w && py >= 0 && py < h) begin
        colour_mem[py*SIDE + px] = col;
        if (cnt < 16384) cnt++;
      end
      err += de;
      if (err >= dx) begin
        y += stp;
        err -= 2 * dx;
      end
    end
    return CNTW'(cnt);
  endfunction

  // edge-function fill with depth interpolation and depth test
  function automatic pixel_result_t fill_triangle(input int ax, ay, bx, by, cx, cy,
                                                  input longint za, zb, zc,
                                                  input logic [COLW-1:0] col);
    pixel_result_t r;
    longint s, w0, w1, w2;
    longint unsigned num, d;
    int lox, loy, hix, hiy, cnt, idx;
    r = '0;
    cnt = 0;
    if (za == 0 || zb == 0 || zc == 0 ||
        za > DEPTH_ONE || zb > DEPTH_ONE || zc > DEPTH_ONE) begin
      r.status = ST_DEPTH;
      return r;
    end
    s = edge_fn(ax, ay, bx, by, cx, cy);
    if (s == 0) begin
      r.status = ST_AREA;
      return r;
    end
    lox = (ax < bx) ? ax : bx; lox = (cx < lox) ? cx : lox;
    loy = (ay < by) ? ay : by; loy = (cy < loy) ? cy : loy;
    hix = (ax > bx) ? ax : bx; hix = (cx > hix) ? cx : hix;
    hiy = (ay > by) ? ay : by; hiy = (cy > hiy) ? cy : hiy;
    if (lox < 0) lox = 0;
    if (loy < 0) loy = 0;
    if (hix > clip_dim(frame_w) - 1) hix = clip_dim(frame_w) - 1;
    if (hiy > clip_dim(frame_h) - 1) hiy = clip_dim(frame_h) - 1;
    for (int y = loy; y <= hiy; y++) begin
      for (int x = lox; x <= hix; x++) begin
        w0 = edge_fn(bx, by, cx, cy, x, y);
        w1 = edge_fn(cx, cy, ax, ay, x, y);
        w2 = edge_fn(ax, ay, bx, by, x, y);
        if (w0 > 0 || w1 > 0 || w2 > 0 || s >= 0) continue;
        num = longint'(-w0) * za + longint'(-w1) * zb + longint'(-w2) * zc;
        d = num / longint'(-s);
        idx = y*SIDE + x;
        if (d < depth_mem[idx]) continue;
        depth_mem[idx] = d[ZW-1:0];
        colour_mem[idx] = col;
        if (cnt < 16384) cnt++;
      end
    end
    r.status = ST_OK;
    r.count = CNTW'(cnt);
    return r;
  endfunction

  function automatic pixel_result_t predict(input logic [1:0] op,
                                            input logic [IN_DW-1:0] d);
    pixel_result_t r;
    int ax, ay, bx, by, cx, cy;
    ax = $signed(d[11:0]);  ay = $signed(d[23:12]);
    bx = $signed(d[35:24]); by = $signed(d[47:36]);
    cx = $signed(d[59:48]); cy = $signed(d[71:60]);
    r = '0;
    case (op)
      OP_LINE: r.count = draw_line(ax, ay, bx, by, d[154:123]);
      OP_TRI: r = fill_triangle(ax, ay, bx, by, cx, cy, longint'(d[88:72]),
                                longint'(d[105:89]), longint'(d[122:106]),
                                d[154:123]);
      OP_READ: begin
        if (ax >= 0 && ax < clip_dim(frame_w) && ay >= 0 && ay < clip_dim(frame_h))
        begin
          r.colour = colour_mem[ay*SIDE + ax];
          r.depth = depth_mem[ay*SIDE + ax];
        end else begin
          r.status = ST_OFFSCREEN;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst_n) begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == 1'b0) frame_w = pwdata[7:0];
        else frame_h = pwdata[7:0];
      end
      // accepted request
      if (in_tvalid && in_tready) result_q.push_back(predict(in_tuser, in_tdata));
      // accepted result
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] !== exp_r.colour) begin
            $error("read_colour: expected %h, got %h", exp_r.colour, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[48:32] !== exp_r.depth) begin
            $error("read_depth: expected %0d, got %0d", exp_r.depth, out_tdata[48:32]);
            fail_count++;
          end
          if (out_tdata[63:49] !== exp_r.count) begin
            $error("pixels_written: expected %0d, got %0d", exp_r.count,
                   out_tdata[63:49]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

[test/tb_line_triangle_raster_engine.sv]
`timescale 1ns / 100ps

module tb_line_triangle_raster_engine;
  import ltre_pkg::*;

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 80;

  // spare opcode and register addresses
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [2:0] REG_FRAME_W = 3'd0;
  localparam logic [2:0] REG_FRAME_H = 3'd4;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  bit                no_idle = 1'b0;
  longint            cycles = 0;

  always #6 clk = ~clk;

  line_triangle_raster_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  raster_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_triangle_raster_engine regression: fail");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready = no_idle || ($urandom_range(99) >= 16);
  end

  // one request: vertices, depths and paint
  task automatic send_request(input logic [1:0] op, input int ax, ay, bx, by,
                              cx, cy, input logic [16:0] az, bz, cz,
                              input logic [31:0] paint);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = op;
    in_tdata = {5'b0, paint, cz, bz, az, 12'(cy), 12'(cx), 12'(by), 12'(bx),
                12'(ay), 12'(ax)};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic int rnd12();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic logic [16:0] good_z();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 17'd65536;
    if (r == 1) return 17'd1;
    return 17'($urandom_range(65536, 1));
  endfunction

  // one random request, weighted toward small on-screen primitives
  task automatic random_request();
    int r, ax, ay, bx, by, cx, cy, t, dx, dy, k, m;
    longint s;
    logic [16:0] az, bz, cz;
    r = $urandom_range(99);
    if (r < 30) begin
      if ($urandom_range(3) == 0) begin
        ax = rnd12(); ay = rnd12(); bx = rnd12(); by = rnd12();
      end else begin
        ax = $urandom_range(170) - 20; ay = $urandom_range(170) - 20;
        bx = $urandom_range(170) - 20; by = $urandom_range(170) - 20;
      end
      send_request(OP_LINE, ax, ay, bx, by, rnd12(), rnd12(), 17'($urandom),
                   17'($urandom), 17'($urandom), $urandom);
    end else if (r < 65) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // small triangle near the screen, mostly covering orientation
        t = $urandom_range(150) - 10; k = $urandom_range(150) - 10;
        ax = t + $urandom_range(24) - 12; ay = k + $urandom_range(24) - 12;
        bx = t + $urandom_range(24) - 12; by = k + $urandom_range(24) - 12;
        cx = t + $urandom_range(24) - 12; cy = k + $urandom_range(24) - 12;
        s = longint'(cx - ax) * (by - ay) - longint'(bx - ax) * (cy - ay);
        if (s > 0 && $urandom_range(9) < 8) begin
          t = bx; bx = cx; cx = t;
          t = by; by = cy; cy = t;
        end
        send_request(OP_TRI, ax, ay, bx, by, cx, cy, good_z(), good_z(), good_z(),
                     $urandom);
      end else if (r < 85) begin
        // depth out of range, any coordinates
        az = 17'($urandom); bz = 17'($urandom); cz = 17'($urandom);
        case ($urandom_range(2))
          0: az = ($urandom_range(1) == 0) ? 17'd0 : 17'($urandom_range(131071, 65537));
          1: bz = ($urandom_range(1) == 0) ? 17'd0 : 17'($urandom_range(131071, 65537));
          default: cz = ($urandom_range(1) == 0) ? 17'd0
                                                 : 17'($urandom_range(131071, 65537));
        endcase
        send_request(OP_TRI, rnd12(), rnd12(), rnd12(), rnd12(), rnd12(), rnd12(),
                     az, bz, cz, $urandom);
      end else begin
        // collinear vertices
        ax = $urandom_range(2000) - 1000; ay = $urandom_range(2000) - 1000;
        dx = $urandom_range(14) - 7; dy = $urandom_range(14) - 7;
        k = $urandom_range(200) - 100; m = $urandom_range(200) - 100;
        send_request(OP_TRI, ax, ay, ax + k*dx, ay + k*dy, ax + m*dx, ay + m*dy,
                     good_z(), good_z(), good_z(), $urandom);
      end
    end else if (r < 95) begin
      if ($urandom_range(6) == 0) begin
        ax = rnd12(); ay = rnd12();
      end else begin
        ax = $urandom_range(129) - 1; ay = $urandom_range(129) - 1;
      end
      send_request(OP_READ, ax, ay, rnd12(), rnd12(), rnd12(), rnd12(),
                   17'($urandom), 17'($urandom), 17'($urandom), $urandom);
    end else begin
      send_request(OP_SPARE, rnd12(), rnd12(), rnd12(), rnd12(), rnd12(), rnd12(),
                   17'($urandom), 17'($urandom), 17'($urandom), $urandom);
    end
  endtask

  initial begin
    int widths[NUM_PHASES];
    int heights[NUM_PHASES];
    widths  = '{255, 1, 0, 128, 0, 128, 0};
    heights = '{255, 1, 128, 0, 0, 128, 0};
    widths[4] = $urandom_range(127, 2); heights[4] = $urandom_range(127, 2);
    widths[6] = $urandom_range(255, 129); heights[6] = $urandom_range(127, 60);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: lines of several slopes, triangle cases, reads and the spare op
    send_request(OP_LINE, 0, 5, 127, 5, 0, 0, 17'd0, 17'd0, 17'd0, 32'hFFFF_FFFF);
    send_request(OP_LINE, 7, 127, 7, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0000_0000);
    send_request(OP_LINE, 120, 3, 10, 90, 0, 0, 17'd0, 17'd0, 17'd0, 32'h1234_5678);
    send_request(OP_LINE, 50, 50, 50, 50, 0, 0, 17'd0, 17'd0, 17'd0, 32'hA5A5_A5A5);
    send_request(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 17'd0, 17'd0, 17'd0,
                 32'h0F0F_0F0F);
    send_request(OP_LINE, 2047, -2048, -2048, 2047, 0, 0, 17'd0, 17'd0, 17'd0,
                 32'hC3C3_C3C3);
    send_request(OP_TRI, 10, 10, 10, 30, 30, 10, 17'd65536, 17'd1, 17'd32768,
                 32'hDEAD_BEEF);
    send_request(OP_TRI, 10, 10, 30, 10, 10, 30, 17'd100, 17'd100, 17'd100,
                 32'h0BAD_F00D);
    send_request(OP_TRI, 12, 12, 12, 28, 26, 12, 17'd1, 17'd1, 17'd1, 32'h1111_1111);
    send_request(OP_TRI, 0, 0, 0, 60, 60, 0, 17'd65536, 17'd65536, 17'd65536,
                 32'h2222_2222);
    send_request(OP_TRI, -20, 100, 140, 140, 110, 90, 17'd40000, 17'd20000, 17'd5,
                 32'h3333_3333);
    send_request(OP_TRI, 1, 1, 1, 9, 9, 1, 17'd0, 17'd5, 17'd5, 32'h4);
    send_request(OP_TRI, 1, 1, 1, 9, 9, 1, 17'd5, 17'd65537, 17'd5, 32'h5);
    send_request(OP_TRI, -2048, 2047, 2047, -2048, 0, 0, 17'd5, 17'd5, 17'd131071, 32'h6);
    send_request(OP_TRI, 3, 3, 6, 6, 9, 9, 17'd5, 17'd5, 17'd5, 32'h7);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0);
    send_request(OP_READ, 127, 127, 0, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0);
    send_request(OP_READ, 15, 15, 0, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0);
    send_request(OP_READ, -1, 0, 0, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0);
    send_request(OP_READ, 2047, -2048, 0, 0, 0, 0, 17'd0, 17'd0, 17'd0, 32'h0);
    send_request(OP_SPARE, -1, -1, -1, -1, -1, -1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                 32'hFFFF_FFFF);

    // random phases, each under its own screen size
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      reg_write(REG_FRAME_W, {16'($urandom_range(16'hFFFF)), 8'($urandom),
                              8'(widths[p])});
      reg_write(REG_FRAME_H, {16'($urandom_range(16'hFFFF)), 8'($urandom),
                              8'(heights[p])});
      no_idle = (p == 3);
      repeat (PHASE_ITEMS) random_request();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (100) @(negedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("line_triangle_raster_engine regression: pass");
    end else begin
      $display("line_triangle_raster_engine regression: fail");
    end
    $finish;
  end

endmodule

[line_triangle_raster_engine.f]
src/ltre_pkg.sv
src/ltre_ram.sv
src/line_triangle_raster_engine.sv
src/ltre_checker.sv
test/raster_checker.sv
test/tb_line_triangle_raster_engine.sv
